// File: rtl/i2cmba_pkg.sv
// Shared types and codes for the I2C master byte access unit.
package i2cmba_pkg;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    // register index, taken from paddr[2]
    localparam logic REG_DEVICE_ADDRESS = 1'b0;
    localparam logic REG_TEN_BIT_MODE   = 1'b1;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_WRITE = 2'd3;

    typedef struct packed {
        logic [9:0] device_address;
        logic       ten_bit_mode;
    } t_cfg;

endpackage

// File: rtl/i2cmba_if.sv
// Command and result channel interfaces of the I2C master byte access unit.
interface i2cmba_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       sda_in;
    logic [7:0] start_offset;
    logic [4:0] transfer_length;
    logic [3:0] load_index;
    logic [7:0] load_byte;

    modport source (
        output valid, mode, sda_in, start_offset, transfer_length, load_index, load_byte,
        input  ready
    );
    modport sink (
        input  valid, mode, sda_in, start_offset, transfer_length, load_index, load_byte,
        output ready
    );
endinterface

interface i2cmba_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [3:0] read_index;
    logic       done_res;
    logic       status;

    modport source (
        output valid, scl_out, sda_out, busy_res, read_valid, read_byte, read_index,
               done_res, status,
        input  ready
    );
    modport sink (
        input  valid, scl_out, sda_out, busy_res, read_valid, read_byte, read_index,
               done_res, status,
        output ready
    );
endinterface

// File: rtl/i2cmba_ram.sv
// Generic single-port-write, registered-read RAM.
module i2cmba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/i2cmba_apb.sv
// APB configuration registers: device address and 10-bit mode.
module i2cmba_apb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [i2cmba_pkg::CFG_AW-1:0] paddr,
    input  logic [i2cmba_pkg::CFG_DW-1:0] pwdata,
    output logic [i2cmba_pkg::CFG_DW-1:0] prdata,
    output logic                          pready,
    output i2cmba_pkg::t_cfg              o_cfg
);
    import i2cmba_pkg::*;

    logic [9:0] r_device_address;
    logic       r_ten_bit_mode;
    logic       wr_en;
    logic       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= '0;
            r_ten_bit_mode   <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DEVICE_ADDRESS: r_device_address <= pwdata[9:0];
                REG_TEN_BIT_MODE:   r_ten_bit_mode   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DEVICE_ADDRESS: prdata = {22'd0, r_device_address};
            REG_TEN_BIT_MODE:   prdata = {31'd0, r_ten_bit_mode};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.device_address = r_device_address;
    assign o_cfg.ten_bit_mode   = r_ten_bit_mode;

endmodule

// File: rtl/i2cmba_seq.sv
// Bus sequencer: one line step per tick word, write buffer access, result register.
module i2cmba_seq #(
    parameter int BUFFER_DEPTH = 16,
    parameter int BUF_AW       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2cmba_pkg::t_cfg    i_cfg,
    i2cmba_cmd_if.sink          i_cmd,
    i2cmba_res_if.source        o_res,
    output logic                o_buf_we,
    output logic [BUF_AW-1:0]   o_buf_waddr,
    output logic [7:0]          o_buf_wdata,
    output logic [BUF_AW-1:0]   o_buf_raddr,
    input  logic [7:0]          i_buf_rdata
);
    import i2cmba_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_SEND  = 3'd2;
    localparam logic [2:0] PH_RECV  = 3'd3;
    localparam logic [2:0] PH_STOP  = 3'd4;

    localparam logic [2:0] ST_SELW = 3'd0;
    localparam logic [2:0] ST_WA1  = 3'd1;
    localparam logic [2:0] ST_WA2  = 3'd2;
    localparam logic [2:0] ST_OFF  = 3'd3;
    localparam logic [2:0] ST_DATA = 3'd4;
    localparam logic [2:0] ST_SELR = 3'd5;
    localparam logic [2:0] ST_RA1  = 3'd6;
    localparam logic [2:0] ST_RECV = 3'd7;

    localparam logic [BUF_AW-1:0] BUF_LAST = BUF_AW'(BUFFER_DEPTH - 1);

    logic [2:0]        r_phase, n_phase;
    logic [2:0]        r_stage, n_stage;
    logic [1:0]        r_sub, n_sub;
    logic [3:0]        r_bit_count, n_bit_count;
    logic [7:0]        r_shift, n_shift;
    logic [7:0]        r_offset, n_offset;
    logic [4:0]        r_remaining, n_remaining;
    logic [3:0]        r_byte_pos, n_byte_pos;
    logic [BUF_AW-1:0] r_buf_idx, n_buf_idx;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic              r_reading, n_reading;
    logic              r_failed, n_failed;

    logic              r_out_valid;
    logic              r_out_scl, r_out_sda, r_out_busy, r_out_rvalid, r_out_done;
    logic              r_out_status;
    logic [7:0]        r_out_rbyte;
    logic [3:0]        r_out_rindex;

    logic              accept;
    logic              busy;
    logic              idx_ok;
    logic [8:0]        load_idx_ext;
    logic              rvalid, done;
    logic [7:0]        rbyte;
    logic [3:0]        rindex;
    logic              pd_req, pd_nack;
    logic              p_send, p_start, p_stop, p_recv, p_after_sel;
    logic [2:0]        p_stage;
    logic [7:0]        p_val;

    function automatic logic [7:0] first_addr(input t_cfg cfg, input logic dir);
        if (cfg.ten_bit_mode) begin
            first_addr = {5'b11110, cfg.device_address[9:8], dir};
        end else begin
            first_addr = {cfg.device_address[6:0], dir};
        end
    endfunction

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign busy        = (r_phase != PH_IDLE);

    assign load_idx_ext = {5'd0, i_cmd.load_index};
    assign idx_ok       = (load_idx_ext < 9'(BUFFER_DEPTH));

    assign o_buf_we    = accept && !busy && (i_cmd.mode == MODE_LOAD) && idx_ok;
    assign o_buf_waddr = load_idx_ext[BUF_AW-1:0];
    assign o_buf_wdata = i_cmd.load_byte;
    // read the current slot every cycle; it settles long before the offset ack needs it
    assign o_buf_raddr = r_buf_idx;

    always_comb begin
        n_phase     = r_phase;
        n_stage     = r_stage;
        n_sub       = r_sub;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_offset    = r_offset;
        n_remaining = r_remaining;
        n_byte_pos  = r_byte_pos;
        n_buf_idx   = r_buf_idx;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_reading   = r_reading;
        n_failed    = r_failed;
        rvalid      = 1'b0;
        done        = 1'b0;
        rbyte       = 8'd0;
        rindex      = 4'd0;
        pd_req      = 1'b0;
        pd_nack     = 1'b0;
        p_send      = 1'b0;
        p_start     = 1'b0;
        p_stop      = 1'b0;
        p_recv      = 1'b0;
        p_after_sel = 1'b0;
        p_stage     = ST_SELW;
        p_val       = 8'd0;

        if (!busy) begin
            if (i_cmd.mode == MODE_READ || i_cmd.mode == MODE_WRITE) begin
                n_reading   = (i_cmd.mode == MODE_READ);
                n_offset    = i_cmd.start_offset;
                n_remaining = i_cmd.transfer_length;
                n_byte_pos  = 4'd0;
                n_buf_idx   = '0;
                n_failed    = 1'b0;
                n_stage     = ST_SELW;
                n_phase     = PH_START;
                n_sub       = 2'd0;
            end
        end else if (i_cmd.mode == MODE_TICK) begin
            unique case (r_phase)
                PH_START: begin
                    unique case (r_sub)
                        2'd0:    n_scl = 1'b1;
                        2'd1:    n_sda = 1'b0;
                        2'd2:    n_scl = 1'b0;
                        default: n_sda = 1'b1;
                    endcase
                    if (r_sub == 2'd3) begin
                        pd_req = 1'b1;
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
                PH_SEND: begin
                    if (!r_bit_count[3]) begin
                        unique case (r_sub)
                            2'd0:    n_sda = r_shift[7];
                            2'd1:    n_scl = 1'b1;
                            2'd2:    n_scl = 1'b0;
                            default: n_sda = 1'b1;
                        endcase
                        if (r_sub == 2'd3) begin
                            n_sub       = 2'd0;
                            n_shift     = {r_shift[6:0], 1'b0};
                            n_bit_count = r_bit_count + 4'd1;
                        end else begin
                            n_sub = r_sub + 2'd1;
                        end
                    end else if (r_sub == 2'd0) begin
                        // ack slot: sample the target's answer on the rising clock
                        n_scl    = 1'b1;
                        n_failed = i_cmd.sda_in;
                        n_sub    = 2'd1;
                    end else begin
                        n_scl   = 1'b0;
                        pd_req  = 1'b1;
                        pd_nack = r_failed;
                    end
                end
                PH_RECV: begin
                    if (!r_bit_count[3]) begin
                        if (r_sub == 2'd0) begin
                            n_scl   = 1'b1;
                            n_shift = {r_shift[6:0], i_cmd.sda_in};
                            if (r_bit_count == 4'd7) begin
                                rvalid = 1'b1;
                                rbyte  = n_shift;
                                rindex = r_byte_pos;
                            end
                            n_sub = 2'd1;
                        end else begin
                            n_scl       = 1'b0;
                            n_sub       = 2'd0;
                            n_bit_count = r_bit_count + 4'd1;
                        end
                    end else begin
                        // master NACK
                        unique case (r_sub)
                            2'd0:    n_sda = 1'b1;
                            2'd1:    n_scl = 1'b1;
                            2'd2:    n_scl = 1'b0;
                            default: n_sda = 1'b1;
                        endcase
                        if (r_sub == 2'd3) begin
                            pd_req = 1'b1;
                        end else begin
                            n_sub = r_sub + 2'd1;
                        end
                    end
                end
                PH_STOP: begin
                    unique case (r_sub)
                        2'd0:    n_sda = 1'b0;
                        2'd1:    n_scl = 1'b1;
                        default: n_sda = 1'b1;
                    endcase
                    if (r_sub == 2'd2) begin
                        n_phase = PH_IDLE;
                        n_sub   = 2'd0;
                        done    = 1'b1;
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
                default: ;
            endcase
        end

        // end of one bus primitive: choose the next one
        if (pd_req) begin
            if (pd_nack) begin
                n_failed = 1'b1;
                p_stop   = 1'b1;
            end else begin
                unique case (r_stage)
                    ST_SELW: begin
                        p_send  = 1'b1;
                        p_stage = ST_WA1;
                        p_val   = first_addr(i_cfg, 1'b0);
                    end
                    ST_WA1: begin
                        if (i_cfg.ten_bit_mode) begin
                            p_send  = 1'b1;
                            p_stage = ST_WA2;
                            p_val   = i_cfg.device_address[7:0];
                        end else begin
                            p_after_sel = 1'b1;
                        end
                    end
                    ST_WA2: p_after_sel = 1'b1;
                    ST_OFF: begin
                        if (r_reading) begin
                            p_start = 1'b1;
                            p_stage = ST_SELR;
                        end else begin
                            p_send  = 1'b1;
                            p_stage = ST_DATA;
                            p_val   = i_buf_rdata;
                        end
                    end
                    ST_DATA, ST_RECV: begin
                        n_byte_pos = r_byte_pos + 4'd1;
                        if (r_byte_pos == 4'd15 || r_buf_idx == BUF_LAST) begin
                            n_buf_idx = '0;
                        end else begin
                            n_buf_idx = r_buf_idx + BUF_AW'(1);
                        end
                        p_start = 1'b1;
                        p_stage = ST_SELW;
                    end
                    ST_SELR: begin
                        p_send  = 1'b1;
                        p_stage = ST_RA1;
                        p_val   = first_addr(i_cfg, 1'b1);
                    end
                    default: p_recv = 1'b1;
                endcase
                if (p_after_sel) begin
                    if (r_remaining == 5'd0) begin
                        p_stop = 1'b1;
                    end else begin
                        n_remaining = r_remaining - 5'd1;
                        n_offset    = r_offset + 8'd1;
                        p_send      = 1'b1;
                        p_stage     = ST_OFF;
                        p_val       = r_offset;
                    end
                end
            end
        end

        if (p_send) begin
            n_phase     = PH_SEND;
            n_stage     = p_stage;
            n_sub       = 2'd0;
            n_bit_count = 4'd0;
            n_shift     = p_val;
        end
        if (p_start) begin
            n_phase = PH_START;
            n_stage = p_stage;
            n_sub   = 2'd0;
        end
        if (p_stop) begin
            n_phase = PH_STOP;
            n_sub   = 2'd0;
        end
        if (p_recv) begin
            n_phase     = PH_RECV;
            n_stage     = ST_RECV;
            n_sub       = 2'd0;
            n_bit_count = 4'd0;
            n_shift     = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_stage     <= ST_SELW;
            r_sub       <= 2'd0;
            r_bit_count <= 4'd0;
            r_shift     <= 8'd0;
            r_offset    <= 8'd0;
            r_remaining <= 5'd0;
            r_byte_pos  <= 4'd0;
            r_buf_idx   <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_reading   <= 1'b0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_stage     <= n_stage;
                r_sub       <= n_sub;
                r_bit_count <= n_bit_count;
                r_shift     <= n_shift;
                r_offset    <= n_offset;
                r_remaining <= n_remaining;
                r_byte_pos  <= n_byte_pos;
                r_buf_idx   <= n_buf_idx;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_reading   <= n_reading;
                r_failed    <= n_failed;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_scl    <= n_scl;
            r_out_sda    <= n_sda;
            r_out_busy   <= (n_phase != PH_IDLE);
            r_out_rvalid <= rvalid;
            r_out_rbyte  <= rbyte;
            r_out_rindex <= rindex;
            r_out_done   <= done;
            r_out_status <= done && n_failed;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.scl_out    = r_out_scl;
    assign o_res.sda_out    = r_out_sda;
    assign o_res.busy_res   = r_out_busy;
    assign o_res.read_valid = r_out_rvalid;
    assign o_res.read_byte  = r_out_rbyte;
    assign o_res.read_index = r_out_rindex;
    assign o_res.done_res   = r_out_done;
    assign o_res.status     = r_out_status;

    a_one_line_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ($countones({r_scl, r_sda} ^ $past({r_scl, r_sda})) <= 1))
        else $error("both bus lines changed on one word");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> (r_phase == PH_IDLE && !r_out_busy))
        else $error("done reported while a transfer is still running");

    a_rvalid_recv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rvalid) |-> (r_phase == PH_RECV && r_stage == ST_RECV))
        else $error("received byte presented outside the receive phase");

    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= 4'd8)
        else $error("bit counter past eight");

    a_buf_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_buf_we |=> ($past(r_phase) == PH_IDLE && r_phase == PH_IDLE))
        else $error("write buffer loaded during a transfer");

endmodule

// File: rtl/i2c_master_byte_access_unit.sv
// I2C master byte access unit: top level with configuration port, sequencer and write buffer.
//
// The unit drives SCL and SDA levels of an I2C bus, one line change per tick word on the
// command channel, and runs random-access reads and writes of up to 31 bytes from a start
// offset, each byte as its own addressed exchange, with 7-bit or 10-bit addressing set
// through the APB registers (device_address at 0x0, ten_bit_mode at 0x4). Every command
// word yields exactly one result word; a new word is taken every cycle while the result
// register is free or being drained, so the throughput is one word per clock. Write data
// is loaded into a BUFFER_DEPTH-entry RAM with a registered read port; the sequencer reads
// the current slot every cycle, so no clearing pass or stall is needed. Configure only
// while the unit is idle.
module i2c_master_byte_access_unit #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [i2cmba_pkg::CFG_AW-1:0] paddr,
    input  logic [i2cmba_pkg::CFG_DW-1:0] pwdata,
    output logic [i2cmba_pkg::CFG_DW-1:0] prdata,
    output logic                          pready,
    i2cmba_cmd_if.sink                    i_cmd,
    i2cmba_res_if.source                  o_res
);
    import i2cmba_pkg::*;

    localparam int BUF_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    t_cfg              cfg;
    logic              buf_we;
    logic [BUF_AW-1:0] buf_waddr;
    logic [7:0]        buf_wdata;
    logic [BUF_AW-1:0] buf_raddr;
    logic [7:0]        buf_rdata;

    i2cmba_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    i2cmba_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH),
        .AW    (BUF_AW)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    i2cmba_seq #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .BUF_AW       (BUF_AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (i_cmd),
        .o_res       (o_res),
        .o_buf_we    (buf_we),
        .o_buf_waddr (buf_waddr),
        .o_buf_wdata (buf_wdata),
        .o_buf_raddr (buf_raddr),
        .i_buf_rdata (buf_rdata)
    );

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the I2C master byte access unit.
`timescale 1ns / 100ps

module testbench;
    import i2cmba_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int WORDS_PER_PHASE = 40;

    typedef struct packed {
        logic [1:0] mode;
        logic       sda_in;
        logic [7:0] start_offset;
        logic [4:0] transfer_length;
        logic [3:0] load_index;
        logic [7:0] load_byte;
    } t_i2c_cmd;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       rvalid;
        logic [7:0] rbyte;
        logic [3:0] rindex;
        logic       done;
        logic       status;
    } t_i2c_res;

    typedef enum logic [2:0] {LN_IDLE, LN_START, LN_SEND, LN_RECV, LN_STOP} t_line_phase;
    typedef enum logic [2:0] {
        EX_SELW, EX_WA1, EX_WA2, EX_OFF, EX_DATA, EX_SELR, EX_RA1, EX_RECV
    } t_exchange;

    class t_bus_scoreboard;
        bit [9:0]    dev_addr;
        bit          ten_bit;
        t_line_phase phase;
        t_exchange   exch;
        bit [1:0]    sub;
        bit [3:0]    bit_cnt;
        bit [7:0]    shreg;
        bit [7:0]    offset;
        bit [4:0]    remain;
        bit [3:0]    byte_pos;
        bit          scl;
        bit          sda;
        bit          reading;
        bit          failed;
        bit [7:0]    wbuf [16];
        t_i2c_res    pending_levels [$];
        int          errors;

        function new();
            dev_addr = '0;
            ten_bit  = 1'b0;
            phase    = LN_IDLE;
            exch     = EX_SELW;
            sub      = '0;
            bit_cnt  = '0;
            shreg    = '0;
            offset   = '0;
            remain   = '0;
            byte_pos = '0;
            scl      = 1'b1;
            sda      = 1'b1;
            reading  = 1'b0;
            failed   = 1'b0;
            errors   = 0;
            foreach (wbuf[i]) wbuf[i] = '0;
        endfunction

        function void set_register(logic idx, bit [31:0] value);
            if (idx == REG_DEVICE_ADDRESS) begin
                dev_addr = value[9:0];
            end else begin
                ten_bit = value[0];
            end
        endfunction

        function bit [7:0] addr_byte(bit rd);
            if (ten_bit) return {5'b11110, dev_addr[9:8], rd};
            return {dev_addr[6:0], rd};
        endfunction

        function void begin_send(t_exchange x, bit [7:0] value);
            exch    = x;
            phase   = LN_SEND;
            sub     = '0;
            bit_cnt = '0;
            shreg   = value;
        endfunction

        function void begin_start(t_exchange x);
            exch  = x;
            phase = LN_START;
            sub   = '0;
        endfunction

        function void begin_stop();
            phase = LN_STOP;
            sub   = '0;
        endfunction

        // after the write select: either the next offset or the closing stop
        function void offset_or_stop();
            if (remain == 0) begin
                begin_stop();
            end else begin
                remain--;
                begin_send(EX_OFF, offset);
                offset++;
            end
        endfunction

        function void exchange_done(bit nack);
            if (nack) begin
                failed = 1'b1;
                begin_stop();
                return;
            end
            case (exch)
                EX_SELW: begin_send(EX_WA1, addr_byte(1'b0));
                EX_WA1: begin
                    if (ten_bit) begin_send(EX_WA2, dev_addr[7:0]);
                    else offset_or_stop();
                end
                EX_WA2: offset_or_stop();
                EX_OFF: begin
                    if (reading) begin_start(EX_SELR);
                    else begin_send(EX_DATA, wbuf[byte_pos]);
                end
                EX_DATA, EX_RECV: begin
                    byte_pos++;
                    begin_start(EX_SELW);
                end
                EX_SELR: begin_send(EX_RA1, addr_byte(1'b1));
                default: begin
                    exch    = EX_RECV;
                    phase   = LN_RECV;
                    sub     = '0;
                    bit_cnt = '0;
                    shreg   = '0;
                end
            endcase
        endfunction

        // Advance the bus by one accepted word; returns 0 when the word is ignored.
        function bit advance_bus(t_i2c_cmd c);
            t_i2c_res e;
            bit       acted;
            e = '0;
            acted = 1'b1;
            if (phase == LN_IDLE) begin
                if (c.mode == MODE_LOAD) begin
                    wbuf[c.load_index] = c.load_byte;
                end else if (c.mode == MODE_TICK) begin
                    acted = 1'b0;
                end else begin
                    reading  = (c.mode == MODE_READ);
                    offset   = c.start_offset;
                    remain   = c.transfer_length;
                    byte_pos = '0;
                    failed   = 1'b0;
                    begin_start(EX_SELW);
                end
            end else if (c.mode != MODE_TICK) begin
                acted = 1'b0;
            end else begin
                case (phase)
                    LN_START: begin
                        case (sub)
                            2'd0: scl = 1'b1;
                            2'd1: sda = 1'b0;
                            2'd2: scl = 1'b0;
                            default: sda = 1'b1;
                        endcase
                        if (sub == 2'd3) exchange_done(1'b0);
                        else sub++;
                    end
                    LN_SEND: begin
                        if (bit_cnt < 8) begin
                            case (sub)
                                2'd0: sda = shreg[7];
                                2'd1: scl = 1'b1;
                                2'd2: scl = 1'b0;
                                default: sda = 1'b1;
                            endcase
                            if (sub == 2'd3) begin
                                sub   = '0;
                                shreg = shreg << 1;
                                bit_cnt++;
                            end else begin
                                sub++;
                            end
                        end else if (sub == 2'd0) begin
                            scl    = 1'b1;
                            failed = c.sda_in;
                            sub    = 2'd1;
                        end else begin
                            scl = 1'b0;
                            exchange_done(failed);
                        end
                    end
                    LN_RECV: begin
                        if (bit_cnt < 8) begin
                            if (sub == 2'd0) begin
                                scl   = 1'b1;
                                shreg = {shreg[6:0], c.sda_in};
                                if (bit_cnt == 7) begin
                                    e.rvalid = 1'b1;
                                    e.rbyte  = shreg;
                                    e.rindex = byte_pos;
                                end
                                sub = 2'd1;
                            end else begin
                                scl = 1'b0;
                                sub = '0;
                                bit_cnt++;
                            end
                        end else begin
                            // NACK clock after the last data bit
                            case (sub)
                                2'd0: sda = 1'b1;
                                2'd1: scl = 1'b1;
                                2'd2: scl = 1'b0;
                                default: sda = 1'b1;
                            endcase
                            if (sub == 2'd3) exchange_done(1'b0);
                            else sub++;
                        end
                    end
                    default: begin
                        case (sub)
                            2'd0: sda = 1'b0;
                            2'd1: scl = 1'b1;
                            default: sda = 1'b1;
                        endcase
                        if (sub == 2'd2) begin
                            phase    = LN_IDLE;
                            sub      = '0;
                            e.done   = 1'b1;
                            e.status = failed;
                        end else begin
                            sub++;
                        end
                    end
                endcase
            end
            e.scl  = scl;
            e.sda  = sda;
            e.busy = (phase != LN_IDLE);
            pending_levels.push_back(e);
            return acted;
        endfunction

        // pick SDA for the next tick: NACK with nack_pct percent odds on acknowledge slots, random elsewhere
        function bit next_sda(int nack_pct);
            if (phase == LN_SEND && bit_cnt == 8 && sub == 2'd0)
                return ($urandom_range(99) < nack_pct);
            return 1'($urandom_range(1));
        endfunction

        task report(string msg);
            errors++;
            // keep the log short on a badly broken run
            if (errors <= 40) $display("%0t MISMATCH: %s", $realtime, msg);
        endtask

        task compare_field(string name, logic [7:0] got, bit [7:0] want);
            if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_word(t_i2c_res r);
            t_i2c_res e;
            if (pending_levels.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            e = pending_levels.pop_front();
            compare_field("scl_out", 8'(r.scl), 8'(e.scl));
            compare_field("sda_out", 8'(r.sda), 8'(e.sda));
            compare_field("busy_res", 8'(r.busy), 8'(e.busy));
            compare_field("read_valid", 8'(r.rvalid), 8'(e.rvalid));
            compare_field("read_byte", r.rbyte, e.rbyte);
            compare_field("read_index", 8'(r.rindex), 8'(e.rindex));
            compare_field("done_res", 8'(r.done), 8'(e.done));
            compare_field("status", 8'(r.status), 8'(e.status));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [CFG_DW-1:0]   pwdata;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    i2cmba_cmd_if cmd_ch();
    i2cmba_res_if res_ch();

    i2c_master_byte_access_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    t_bus_scoreboard bus_model = new();
    int              sender_idle_pct = 0;
    int              receiver_stall_pct = 0;
    int              words_applied = 0;
    int              cycles = 0;
    bit              rx_hold_req = 1'b0;
    t_i2c_res        seen;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            seen = {res_ch.scl_out, res_ch.sda_out, res_ch.busy_res, res_ch.read_valid,
                    res_ch.read_byte, res_ch.read_index, res_ch.done_res, res_ch.status};
            bus_model.check_word(seen);
        end
    end

    function automatic t_i2c_cmd random_cmd(bit [1:0] m);
        t_i2c_cmd c;
        c = $bits(t_i2c_cmd)'($urandom);
        c.mode = m;
        return c;
    endfunction

    // present one word, hold it until taken, then feed it to the model
    task automatic send_word(input t_i2c_cmd c);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid           <= 1'b1;
        cmd_ch.mode            <= c.mode;
        cmd_ch.sda_in          <= c.sda_in;
        cmd_ch.start_offset    <= c.start_offset;
        cmd_ch.transfer_length <= c.transfer_length;
        cmd_ch.load_index      <= c.load_index;
        cmd_ch.load_byte       <= c.load_byte;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        if (bus_model.advance_bus(c)) words_applied++;
    endtask

    task automatic tick(int nack_pct);
        t_i2c_cmd c;
        c = random_cmd(MODE_TICK);
        c.sda_in = bus_model.next_sda(nack_pct);
        send_word(c);
    endtask

    // one whole transfer, optionally salted with commands that must be ignored
    task automatic run_transfer(bit [1:0] op, bit [7:0] off, bit [4:0] len,
                                int nack_pct, int noise_pct);
        t_i2c_cmd c;
        c = random_cmd(op);
        c.start_offset = off;
        c.transfer_length = len;
        send_word(c);
        while (bus_model.phase != LN_IDLE) begin
            if ($urandom_range(99) < noise_pct) send_word(random_cmd(2'($urandom_range(1, 3))));
            else tick(nack_pct);
        end
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (bus_model.pending_levels.size() != 0);
    endtask

    task automatic apb_write(logic idx, bit [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        bus_model.set_register(idx, value);
        @(posedge i_clk);
    endtask

    task automatic configure(bit [9:0] addr, bit ten);
        bit [31:0] v;
        drain();
        v = $urandom;
        v[9:0] = addr;
        apb_write(REG_DEVICE_ADDRESS, v);
        v = $urandom;
        v[0] = ten;
        apb_write(REG_TEN_BIT_MODE, v);
    endtask

    initial begin
        t_i2c_cmd  c;
        int        target;
        int        r;
        int        s;
        bit [1:0]  op;
        bit [4:0]  len;
        int        nack;
        bit [9:0]  addr;
        bit        ten;

        i_rst_n                <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        cmd_ch.valid           <= 1'b0;
        cmd_ch.mode            <= MODE_TICK;
        cmd_ch.sda_in          <= 1'b1;
        cmd_ch.start_offset    <= '0;
        cmd_ch.transfer_length <= '0;
        cmd_ch.load_index      <= '0;
        cmd_ch.load_byte       <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tick while idle: nothing moves
        c = random_cmd(MODE_TICK);
        c.sda_in = 1'b1;
        send_word(c);
        // fill every buffer slot so no write ever sends an unloaded byte
        for (int i = 0; i < 16; i++) begin
            c = random_cmd(MODE_LOAD);
            c.load_index = 4'(i);
            if (i == 0) c.load_byte = 8'h00;
            else if (i == 15) c.load_byte = 8'hFF;
            send_word(c);
        end
        run_transfer(MODE_WRITE, 8'hFF, 5'd0, 0, 0);     // presence probe
        run_transfer(MODE_READ, 8'hFF, 5'd1, 0, 25);     // commands while busy
        run_transfer(MODE_READ, 8'h10, 5'd31, 100, 0);   // missing ACK on the address
        run_transfer(MODE_WRITE, 8'hFF, 5'd2, 0, 0);     // offset wraps

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin addr = 10'h3FF; ten = 1'b0; end
                1: begin addr = 10'h000; ten = 1'b1; end
                2: begin addr = 10'h3FF; ten = 1'b1; end
                3: begin addr = 10'h000; ten = 1'b0; end
                default: begin addr = 10'($urandom); ten = 1'($urandom); end
            endcase
            configure(addr, ten);
            sender_idle_pct    = (p == 1) ? 78 : (p == 3) ? 35 : 0;
            receiver_stall_pct = (p == 2) ? 78 : (p == 3) ? 35 : 0;

            if (p == 0) begin
                // stall the output long enough to back the block up
                rx_hold_req = 1'b1;
                run_transfer(MODE_READ, 8'($urandom), 5'd0, 0, 0);
                drain();
            end

            target = words_applied + WORDS_PER_PHASE;
            while (words_applied < target) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    send_word(random_cmd(MODE_LOAD));
                end else if (r < 11) begin
                    send_word(random_cmd(MODE_TICK));
                end else begin
                    op = $urandom_range(1) ? MODE_READ : MODE_WRITE;
                    s = $urandom_range(99);
                    nack = 3;
                    if (s < 45) begin
                        len = 5'($urandom_range(1));
                    end else if (s < 85) begin
                        len = 5'($urandom_range(4, 2));
                    end else if (s < 93) begin
                        len = 5'($urandom_range(8, 5));
                    end else begin
                        // long lengths, mostly cut short by a missing ACK
                        len = 5'($urandom_range(31, 16));
                        nack = 40;
                    end
                    run_transfer(op, 8'($urandom), len, nack, 5);
                end
            end
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (bus_model.errors == 0 && bus_model.pending_levels.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: i2c_master_byte_access_unit.f
rtl/i2cmba_pkg.sv
rtl/i2cmba_if.sv
rtl/i2cmba_ram.sv
rtl/i2cmba_apb.sv
rtl/i2cmba_seq.sv
rtl/i2c_master_byte_access_unit.sv
dv/testbench.sv
